>>> src/ahc_pkg.sv
package ahc_pkg;

    // Default width of the free-running tick.
    localparam int TICK_WIDTH_DEF = 16;

    localparam int MASK_W      = 4;
    localparam int COUNT_W     = 14;
    localparam int DIGIT_W     = 4;
    localparam int HOLD_W      = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_W       = 32;
    localparam int SMALL_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 14'd9999;
    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd10;
    localparam logic [HOLD_W-1:0]  HOLD_SAT    = 16'hFFFF;

    localparam logic [HOLD_W-1:0] STEP_ONE     = 16'd1;
    localparam logic [HOLD_W-1:0] STEP_TEN     = 16'd10;
    localparam logic [HOLD_W-1:0] STEP_HUNDRED = 16'd100;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_HOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TENS_AFTER   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HUNDS_AFTER  = 8'd3;

    localparam logic [CFG_DATA_W-1:0] INITIAL_HOLD_RST = 16'd30;
    localparam logic [CFG_DATA_W-1:0] REPEAT_RST       = 16'd50;
    localparam logic [CFG_DATA_W-1:0] TENS_AFTER_RST   = 16'd9;
    localparam logic [CFG_DATA_W-1:0] HUNDS_AFTER_RST  = 16'd19;

    typedef enum logic [2:0] {
        BTN_CLEAR = 3'd0,
        BTN_IDLE  = 3'd1,
        BTN_DOWN  = 3'd2,
        BTN_UP    = 3'd3,
        BTN_NONE  = 3'd4
    } btn_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] hundreds_after_repeats;
        logic [CFG_DATA_W-1:0] tens_after_repeats;
        logic [CFG_DATA_W-1:0] repeat_ticks;
        logic [CFG_DATA_W-1:0] initial_hold_ticks;
    } ahc_cfg_t;

    // Packed with the count in the lowest bits.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_units;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_thousands;
        logic [COUNT_W-1:0] count_out;
    } ahc_result_t;

    typedef struct packed {
        logic load_quot;
        logic load_out;
    } ahc_stage_en_t;

    // 16-bit add; a sum beyond the count range wraps to zero.
    function automatic logic [COUNT_W-1:0] add_step(input logic [COUNT_W-1:0] value,
                                                    input logic [HOLD_W-1:0]  delta);
        logic [HOLD_W-1:0] sum;
        sum = HOLD_W'(value) + delta;
        return (sum > HOLD_W'(COUNT_MAX)) ? '0 : sum[COUNT_W-1:0];
    endfunction

    // Quotient by ten of a value below one hundred.
    function automatic logic [DIGIT_W-1:0] div10_small(input logic [SMALL_W-1:0] v);
        logic [DIGIT_W-1:0] q;
        q = '0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= SMALL_W'(10 * k)) begin
                q = q + DIGIT_W'(1);
            end
        end
        return q;
    endfunction

    function automatic logic [SMALL_W-1:0] mul10_small(input logic [DIGIT_W-1:0] v);
        return (SMALL_W'(v) << 3) + (SMALL_W'(v) << 1);
    endfunction

endpackage

>>> src/ahc_cfg_regs.sv
module ahc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [ahc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [ahc_pkg::CFG_DATA_W-1:0]   wr_data,
    output ahc_pkg::ahc_cfg_t                cfg
);
    import ahc_pkg::*;

    ahc_cfg_t cfg_reg;
    ahc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_INITIAL_HOLD: cfg_next.initial_hold_ticks     = wr_data;
                REG_REPEAT:       cfg_next.repeat_ticks           = wr_data;
                REG_TENS_AFTER:   cfg_next.tens_after_repeats     = wr_data;
                REG_HUNDS_AFTER:  cfg_next.hundreds_after_repeats = wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_hold_ticks     <= INITIAL_HOLD_RST;
            cfg_reg.repeat_ticks           <= REPEAT_RST;
            cfg_reg.tens_after_repeats     <= TENS_AFTER_RST;
            cfg_reg.hundreds_after_repeats <= HUNDS_AFTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/ahc_hold_ctrl.sv
module ahc_hold_ctrl #(
    parameter int TICK_WIDTH = ahc_pkg::TICK_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [ahc_pkg::MASK_W-1:0]    pressed_mask,
    input  logic [TICK_WIDTH-1:0]         now_tick,
    input  ahc_pkg::ahc_cfg_t             cfg,
    output logic [ahc_pkg::COUNT_W-1:0]   count_value
);
    import ahc_pkg::*;

    localparam int WIDE_W = (TICK_WIDTH > HOLD_W) ? TICK_WIDTH : HOLD_W;
    localparam int HSUM_W = WIDE_W + 1;

    logic [COUNT_W-1:0]    count_reg,       count_next;
    btn_t                  held_reg,        held_next;
    logic [TICK_WIDTH-1:0] last_seen_reg,   last_seen_next;
    logic [HOLD_W-1:0]     held_ticks_reg,  held_ticks_next;
    logic [HOLD_W-1:0]     repeats_reg,     repeats_next;
    logic [TICK_WIDTH-1:0] last_repeat_reg, last_repeat_next;
    logic                  first_done_reg,  first_done_next;

    btn_t                  lead_btn;
    btn_t                  last_btn;
    logic                  multi;
    logic                  same;
    logic [TICK_WIDTH-1:0] base_seen;
    logic [HOLD_W-1:0]     base_held;
    logic [HOLD_W-1:0]     base_repeats;
    logic [TICK_WIDTH-1:0] base_last_repeat;
    logic                  base_first_done;
    logic [TICK_WIDTH-1:0] elapsed;
    logic [HSUM_W-1:0]     held_sum;
    logic [HOLD_W-1:0]     held_sat;
    logic [HOLD_W:0]       repeat_start;
    logic [TICK_WIDTH-1:0] since;
    logic                  interval_due;
    logic                  going_down;
    logic [HOLD_W-1:0]     step_mag;
    logic [HOLD_W-1:0]     delta_one;
    logic [HOLD_W-1:0]     delta_rep;
    logic                  fresh_step;
    logic                  tail_down;
    logic                  tail_up;
    logic [COUNT_W-1:0]    lead_count;
    logic [HOLD_W-1:0]     lead_repeats;
    logic [TICK_WIDTH-1:0] lead_last_repeat;
    logic                  lead_first_done;
    logic [COUNT_W-1:0]    tail_count;

    // Buttons are handled in index order: the lowest pressed one sees the stored
    // hold state, and every later one finds a changed button and starts fresh.
    always_comb begin
        if (pressed_mask[0]) begin
            lead_btn = BTN_CLEAR;
        end else if (pressed_mask[1]) begin
            lead_btn = BTN_IDLE;
        end else if (pressed_mask[2]) begin
            lead_btn = BTN_DOWN;
        end else begin
            lead_btn = BTN_UP;
        end
        if (pressed_mask[3]) begin
            last_btn = BTN_UP;
        end else if (pressed_mask[2]) begin
            last_btn = BTN_DOWN;
        end else if (pressed_mask[1]) begin
            last_btn = BTN_IDLE;
        end else begin
            last_btn = BTN_CLEAR;
        end
    end

    assign multi = (pressed_mask & (pressed_mask - MASK_W'(1))) != '0;
    assign same  = (held_reg == lead_btn);

    assign base_seen        = same ? last_seen_reg   : now_tick;
    assign base_held        = same ? held_ticks_reg  : '0;
    assign base_repeats     = same ? repeats_reg     : '0;
    assign base_last_repeat = same ? last_repeat_reg : '0;
    assign base_first_done  = same ? first_done_reg  : 1'b0;

    assign elapsed  = now_tick - base_seen;
    assign held_sum = HSUM_W'(base_held) + HSUM_W'(elapsed);
    assign held_sat = (held_sum > HSUM_W'(HOLD_SAT)) ? HOLD_SAT : held_sum[HOLD_W-1:0];

    assign repeat_start = {1'b0, cfg.initial_hold_ticks} + {1'b0, cfg.repeat_ticks};
    assign since        = now_tick - base_last_repeat;
    assign interval_due = WIDE_W'(since) >= WIDE_W'(cfg.repeat_ticks);

    always_comb begin
        if (base_repeats > cfg.hundreds_after_repeats) begin
            step_mag = STEP_HUNDRED;
        end else if (base_repeats > cfg.tens_after_repeats) begin
            step_mag = STEP_TEN;
        end else begin
            step_mag = STEP_ONE;
        end
    end

    assign going_down = (lead_btn == BTN_DOWN);
    assign delta_one  = going_down ? (HOLD_W'(0) - STEP_ONE) : STEP_ONE;
    assign delta_rep  = going_down ? (HOLD_W'(0) - step_mag) : step_mag;

    always_comb begin
        lead_count       = count_reg;
        lead_repeats     = base_repeats;
        lead_last_repeat = base_last_repeat;
        lead_first_done  = base_first_done;
        case (lead_btn) inside
            BTN_CLEAR: begin
                lead_count = '0;
            end
            BTN_DOWN, BTN_UP: begin
                if (held_sat < cfg.initial_hold_ticks) begin
                    if (!base_first_done) begin
                        lead_count      = add_step(count_reg, delta_one);
                        lead_first_done = 1'b1;
                    end
                end else if (({1'b0, held_sat} >= repeat_start) && interval_due) begin
                    lead_last_repeat = now_tick;
                    lead_repeats     = (base_repeats == HOLD_SAT) ? base_repeats
                                                                  : base_repeats + HOLD_W'(1);
                    lead_count       = add_step(count_reg, delta_rep);
                end
            end
            default: ;
        endcase
    end

    // A freshly pressed down or up button steps at once when the first-press
    // window is open, or when a zero interval makes the repeat due at once.
    assign fresh_step = (cfg.initial_hold_ticks != '0) || (cfg.repeat_ticks == '0);
    assign tail_down  = pressed_mask[2] && fresh_step &&
                        ((lead_btn == BTN_CLEAR) || (lead_btn == BTN_IDLE));
    assign tail_up    = pressed_mask[3] && fresh_step && (lead_btn != BTN_UP);

    always_comb begin
        if (tail_down && tail_up) begin
            tail_count = (lead_count == '0) ? COUNT_W'(1) : lead_count;
        end else if (tail_down) begin
            tail_count = (lead_count == '0) ? '0 : lead_count - COUNT_W'(1);
        end else if (tail_up) begin
            tail_count = (lead_count >= COUNT_MAX) ? '0 : lead_count + COUNT_W'(1);
        end else begin
            tail_count = lead_count;
        end
    end

    always_comb begin
        count_next       = count_reg;
        held_next        = held_reg;
        last_seen_next   = last_seen_reg;
        held_ticks_next  = held_ticks_reg;
        repeats_next     = repeats_reg;
        last_repeat_next = last_repeat_reg;
        first_done_next  = first_done_reg;
        if (step_en) begin
            if (pressed_mask == '0) begin
                held_next = BTN_NONE;
            end else if (multi) begin
                held_next        = last_btn;
                last_seen_next   = now_tick;
                held_ticks_next  = '0;
                count_next       = tail_count;
                repeats_next     = '0;
                last_repeat_next = '0;
                first_done_next  = 1'b0;
                if (((last_btn == BTN_DOWN) || (last_btn == BTN_UP)) && fresh_step) begin
                    if (cfg.initial_hold_ticks != '0) begin
                        first_done_next = 1'b1;
                    end else begin
                        repeats_next     = HOLD_W'(1);
                        last_repeat_next = now_tick;
                    end
                end
            end else begin
                held_next        = lead_btn;
                last_seen_next   = now_tick;
                held_ticks_next  = held_sat;
                count_next       = lead_count;
                repeats_next     = lead_repeats;
                last_repeat_next = lead_last_repeat;
                first_done_next  = lead_first_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            held_reg        <= BTN_NONE;
            last_seen_reg   <= '0;
            held_ticks_reg  <= '0;
            repeats_reg     <= '0;
            last_repeat_reg <= '0;
            first_done_reg  <= 1'b0;
        end else begin
            count_reg       <= count_next;
            held_reg        <= held_next;
            last_seen_reg   <= last_seen_next;
            held_ticks_reg  <= held_ticks_next;
            repeats_reg     <= repeats_next;
            last_repeat_reg <= last_repeat_next;
            first_done_reg  <= first_done_next;
        end
    end

    assign count_value = count_reg;

endmodule

>>> src/ahc_digit_split.sv
module ahc_digit_split (
    input  logic                         aclk,
    input  ahc_pkg::ahc_stage_en_t       stage_en,
    input  logic [ahc_pkg::COUNT_W-1:0]  count_in,
    output ahc_pkg::ahc_result_t         result
);
    import ahc_pkg::*;

    // Reciprocal of one hundred, exact for every count up to the maximum.
    localparam int                 HUND_SHIFT = 20;
    localparam logic [COUNT_W-1:0] RECIP_100  = 14'd10486;
    localparam int                 PROD_W     = 2 * COUNT_W;

    logic [PROD_W-1:0]  prod;
    logic [SMALL_W-1:0] hund_quot;

    logic [COUNT_W-1:0] quot_count_reg;
    logic [SMALL_W-1:0] quot_hund_reg;
    ahc_result_t        result_reg;
    ahc_result_t        result_next;

    logic [DIGIT_W-1:0] thou_raw;
    logic [DIGIT_W-1:0] hund_raw;
    logic [DIGIT_W-1:0] tens_raw;
    logic [DIGIT_W-1:0] unit_raw;
    logic [COUNT_W-1:0] hund_scaled;
    logic [SMALL_W-1:0] rem_100;

    assign prod      = PROD_W'(count_in) * PROD_W'(RECIP_100);
    assign hund_quot = prod[HUND_SHIFT +: SMALL_W];

    always_ff @(posedge aclk) begin
        if (stage_en.load_quot) begin
            quot_count_reg <= count_in;
            quot_hund_reg  <= hund_quot;
        end
    end

    // q * 100 as shifts and adds.
    assign hund_scaled = (COUNT_W'(quot_hund_reg) << 6) + (COUNT_W'(quot_hund_reg) << 5)
                       + (COUNT_W'(quot_hund_reg) << 2);
    assign rem_100  = SMALL_W'(quot_count_reg - hund_scaled);
    assign thou_raw = div10_small(quot_hund_reg);
    assign hund_raw = DIGIT_W'(quot_hund_reg - mul10_small(thou_raw));
    assign tens_raw = div10_small(rem_100);
    assign unit_raw = DIGIT_W'(rem_100 - mul10_small(tens_raw));

    always_comb begin
        result_next.count_out       = quot_count_reg;
        result_next.digit_thousands = (quot_count_reg < COUNT_W'(1000)) ? BLANK_DIGIT : thou_raw;
        result_next.digit_hundreds  = (quot_count_reg < COUNT_W'(100))  ? BLANK_DIGIT : hund_raw;
        result_next.digit_tens      = (quot_count_reg < COUNT_W'(10))   ? BLANK_DIGIT : tens_raw;
        result_next.digit_units     = unit_raw;
    end

    always_ff @(posedge aclk) begin
        if (stage_en.load_out) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> src/accelerating_hold_updown_counter_top.sv
// Path: the edge that accepts a poll on s_ loads the input register; the hold
// state, quotient and output registers follow in order. Throughput: one poll
// per clock; each stage moves whenever the stage after it is empty or handing
// its request on, so only m_tready stalls the pipe. Reset: aresetn is
// synchronous and active low; it empties the pipe and returns the count, hold
// tracking and registers to defaults.
module accelerating_hold_updown_counter_top #(
    parameter int TICK_WIDTH = ahc_pkg::TICK_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Poll requests.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // From bit 0: pressed_mask (4), now_tick (TICK_WIDTH), zero fill to a byte.
    input  logic [((TICK_WIDTH + ahc_pkg::MASK_W + 7) / 8) * 8 - 1:0] s_tdata,
    // Result requests.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // From bit 0: count_out (14), digit_thousands (4), digit_hundreds (4),
    // digit_tens (4), digit_units (4), zero fill (2).
    output logic [ahc_pkg::OUT_W-1:0]              m_tdata,
    // Register writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ahc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ahc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ahc_pkg::*;

    logic                  in_valid_reg,   in_valid_next;
    logic                  cnt_valid_reg,  cnt_valid_next;
    logic                  quot_valid_reg, quot_valid_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [MASK_W-1:0]     in_mask_reg;
    logic [TICK_WIDTH-1:0] in_tick_reg;

    logic                  out_ready;
    logic                  quot_ready;
    logic                  cnt_ready;
    logic                  in_ready;
    logic                  in_take;
    logic                  step_en;
    ahc_stage_en_t         stage_en;
    ahc_cfg_t              cfg;
    logic [COUNT_W-1:0]    count_value;
    ahc_result_t           result;

    // The register port never stalls; each write is registered at the edge that accepts it.
    assign cfg_ready = 1'b1;

    ahc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Ready flows backward through the four stages: a stage can take a new
    // request when it is empty or its current one moves on in the same cycle.
    assign out_ready  = !out_valid_reg  || m_tready;
    assign quot_ready = !quot_valid_reg || out_ready;
    assign cnt_ready  = !cnt_valid_reg  || quot_ready;
    assign in_ready   = !in_valid_reg   || cnt_ready;

    assign s_tready = in_ready;
    assign in_take  = s_tvalid && in_ready;

    // The hold state advances exactly when the registered poll moves into the
    // count stage; the updated count register then serves as that stage's data.
    assign step_en            = in_valid_reg && cnt_ready;
    assign stage_en.load_quot = cnt_valid_reg && quot_ready;
    assign stage_en.load_out  = quot_valid_reg && out_ready;

    assign in_valid_next   = in_take || (in_valid_reg && !cnt_ready);
    assign cnt_valid_next  = step_en || (cnt_valid_reg && !quot_ready);
    assign quot_valid_next = stage_en.load_quot || (quot_valid_reg && !out_ready);
    assign out_valid_next  = stage_en.load_out || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cnt_valid_reg  <= 1'b0;
            quot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            cnt_valid_reg  <= cnt_valid_next;
            quot_valid_reg <= quot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mask_reg <= s_tdata[MASK_W-1:0];
            in_tick_reg <= s_tdata[MASK_W +: TICK_WIDTH];
        end
    end

    ahc_hold_ctrl #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_hold_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .pressed_mask (in_mask_reg),
        .now_tick     (in_tick_reg),
        .cfg          (cfg),
        .count_value  (count_value)
    );

    ahc_digit_split u_digit_split (
        .aclk     (aclk),
        .stage_en (stage_en),
        .count_in (count_value),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(result);

endmodule

>>> src/ahc_checker.sv
module ahc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ahc_pkg::OUT_W-1:0]  m_tdata
);
    import ahc_pkg::*;

    // Nothing is offered in the cycle after a reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The count stays within its range and the units digit is always a digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:0] <= COUNT_MAX) && (m_tdata[29:26] <= 4'd9))
        else $error("count or units digit out of range");

    // The thousands and tens digits are blank exactly when the count is below their place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[13:0] < 14'd1000) == (m_tdata[17:14] == BLANK_DIGIT)) &&
                     ((m_tdata[13:0] < 14'd10) == (m_tdata[25:22] == BLANK_DIGIT)))
        else $error("digit blanking does not match the count");

endmodule

bind accelerating_hold_updown_counter_top ahc_checker u_ahc_checker (.*);

>>> test/tb_accelerating_hold_updown_counter_top.sv
`timescale 1ns / 1ps

module tb_accelerating_hold_updown_counter_top;

    import ahc_pkg::*;

    localparam int TICK_W      = TICK_WIDTH_DEF;
    localparam int S_W         = ((TICK_W + MASK_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 60;

    // One-hot button levels in the order the block examines them.
    localparam logic [MASK_W-1:0] PRESS_CLEAR = 4'b1 << BTN_CLEAR;
    localparam logic [MASK_W-1:0] PRESS_IDLE  = 4'b1 << BTN_IDLE;
    localparam logic [MASK_W-1:0] PRESS_DOWN  = 4'b1 << BTN_DOWN;
    localparam logic [MASK_W-1:0] PRESS_UP    = 4'b1 << BTN_UP;
    localparam logic [MASK_W-1:0] PRESS_NONE  = '0;

    // Tracks the hold state and the count, and holds the display each
    // accepted poll should produce.
    class hold_count_scoreboard;
        logic [CFG_DATA_W-1:0] init_hold;
        logic [CFG_DATA_W-1:0] rep_ticks;
        logic [CFG_DATA_W-1:0] tens_after;
        logic [CFG_DATA_W-1:0] hunds_after;
        logic [COUNT_W-1:0]    count;
        btn_t                  held;
        logic [TICK_W-1:0]     seen_tick;
        logic [HOLD_W-1:0]     held_ticks;
        logic [HOLD_W-1:0]     repeats;
        logic [TICK_W-1:0]     repeat_tick;
        bit                    first_done;
        ahc_result_t           expected_displays[$];
        int                    errors;

        function new();
            init_hold   = INITIAL_HOLD_RST;
            rep_ticks   = REPEAT_RST;
            tens_after  = TENS_AFTER_RST;
            hunds_after = HUNDS_AFTER_RST;
            count       = '0;
            held        = BTN_NONE;
            seen_tick   = '0;
            held_ticks  = '0;
            repeats     = '0;
            repeat_tick = '0;
            first_done  = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INITIAL_HOLD: init_hold   = val;
                REG_REPEAT:       rep_ticks   = val;
                REG_TENS_AFTER:   tens_after  = val;
                REG_HUNDS_AFTER:  hunds_after = val;
                default: ;
            endcase
        endfunction

        function logic [COUNT_W-1:0] bumped(logic [COUNT_W-1:0] v, logic [HOLD_W-1:0] d);
            logic [HOLD_W-1:0] s;
            s = HOLD_W'(v) + d;
            return (s > HOLD_W'(COUNT_MAX)) ? '0 : s[COUNT_W-1:0];
        endfunction

        function void apply_press(btn_t btn, logic [TICK_W-1:0] now);
            logic [TICK_W-1:0] elapsed;
            logic [TICK_W-1:0] since;
            logic [HOLD_W-1:0] dir;
            logic [HOLD_W-1:0] step;
            logic [HOLD_W:0]   total;
            if (held != btn) begin
                seen_tick   = now;
                held_ticks  = '0;
                repeats     = '0;
                repeat_tick = '0;
                first_done  = 1'b0;
            end
            held = btn;
            elapsed = now - seen_tick;
            seen_tick = now;
            total = {1'b0, held_ticks} + {1'b0, elapsed};
            held_ticks = total[HOLD_W] ? HOLD_SAT : total[HOLD_W-1:0];
            if (btn == BTN_CLEAR) begin
                count = '0;
                return;
            end
            if (btn == BTN_IDLE)
                return;
            dir = (btn == BTN_DOWN) ? HOLD_SAT : STEP_ONE;
            // Inside the first-press window only one step is ever taken.
            if (held_ticks < init_hold) begin
                if (!first_done) begin
                    count = bumped(count, dir);
                    first_done = 1'b1;
                end
                return;
            end
            // The delay sum is taken one bit wider so that it can exceed the held range.
            if ({1'b0, held_ticks} >= {1'b0, init_hold} + {1'b0, rep_ticks}) begin
                step = dir;
                if (repeats > tens_after && repeats <= hunds_after)
                    step = dir * STEP_TEN;
                else if (repeats > hunds_after)
                    step = dir * STEP_HUNDRED;
                since = now - repeat_tick;
                if (since >= rep_ticks) begin
                    repeat_tick = now;
                    if (repeats != HOLD_SAT)
                        repeats = repeats + HOLD_W'(1);
                    count = bumped(count, step);
                end
            end
        endfunction

        function void note_poll(logic [S_W-1:0] req);
            logic [MASK_W-1:0] mask;
            logic [TICK_W-1:0] now;
            ahc_result_t       disp;
            int                c;
            mask = req[MASK_W-1:0];
            now  = req[MASK_W +: TICK_W];
            for (int b = 0; b < MASK_W; b++) begin
                if (mask[b])
                    apply_press(btn_t'(b), now);
            end
            if (mask == PRESS_NONE)
                held = BTN_NONE;
            c = count;
            disp.count_out       = count;
            disp.digit_thousands = (c < 1000) ? BLANK_DIGIT : DIGIT_W'((c / 1000) % 10);
            disp.digit_hundreds  = (c < 100)  ? BLANK_DIGIT : DIGIT_W'((c / 100) % 10);
            disp.digit_tens      = (c < 10)   ? BLANK_DIGIT : DIGIT_W'((c / 10) % 10);
            disp.digit_units     = DIGIT_W'(c % 10);
            expected_displays.push_back(disp);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                // Past this many reports the run has failed anyway.
                if (errors <= MAX_REPORTS)
                    $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            ahc_result_t want;
            ahc_result_t got;
            got = data[$bits(ahc_result_t)-1:0];
            if (expected_displays.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result request with no poll outstanding: %h", data);
                return;
            end
            want = expected_displays.pop_front();
            compare_field("count_out",       want.count_out,       got.count_out);
            compare_field("digit_thousands", want.digit_thousands, got.digit_thousands);
            compare_field("digit_hundreds",  want.digit_hundreds,  got.digit_hundreds);
            compare_field("digit_tens",      want.digit_tens,      got.digit_tens);
            compare_field("digit_units",     want.digit_units,     got.digit_units);
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata;   // pressed_mask (4), now_tick (16), zero fill (4)
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;   // count_out, thousands, hundreds, tens, units, fill
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hold_count_scoreboard sb = new();

    logic [TICK_W-1:0] tick_now = '0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    bit                calm = 1'b0;
    int                rx_hold_left = 0;
    int                cycle_count = 0;

    accelerating_hold_updown_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog over the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_accelerating_hold_updown_counter_top: errors");
            $finish;
        end
    end

    // Requests are observed at the clock edge that completes them.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_poll(s_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
    end

    // Result side back-pressure: random stalls of m_tready, none once calm.
    always @(posedge aclk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(1, 100) <= rx_idle_pct) begin
            rx_hold_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one poll and returns at the edge where it is taken; valid stays
    // high so that a following poll can go back to back.
    task automatic send_poll(input logic [MASK_W-1:0] mask, input logic [TICK_W-1:0] tick);
        if (!calm && $urandom_range(1, 100) <= tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W - TICK_W - MASK_W){1'b0}}, tick, mask};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits for every outstanding result to come back. The
    // first wait lets the scoreboard note the poll taken at the current edge.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all four registers plus one index past the list, which must be ignored.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] init_hold,
                                input logic [CFG_DATA_W-1:0] rep,
                                input logic [CFG_DATA_W-1:0] tens,
                                input logic [CFG_DATA_W-1:0] hunds,
                                input logic [CFG_INDEX_W-1:0] stray_idx);
        settle();
        write_reg(REG_INITIAL_HOLD, init_hold);
        write_reg(REG_REPEAT, rep);
        write_reg(REG_TENS_AFTER, tens);
        write_reg(REG_HUNDS_AFTER, hunds);
        write_reg(stray_idx, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly long holds of up or down with the tick creeping forward, the
    // rest random button combinations and tick jumps.
    task automatic random_polls(input int n, input int max_inc);
        int                done;
        int                kind;
        int                len;
        logic [MASK_W-1:0] mask;
        done = 0;
        while (done < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                mask = ($urandom_range(0, 2) != 0) ? PRESS_UP : PRESS_DOWN;
                len = $urandom_range(1, 60);
                repeat (len) begin
                    tick_now = tick_now + TICK_W'($urandom_range(0, max_inc));
                    send_poll(mask, tick_now);
                end
                done += len;
                if ($urandom_range(0, 1) == 0) begin
                    tick_now = tick_now + TICK_W'($urandom_range(0, max_inc));
                    send_poll(PRESS_NONE, tick_now);
                    done++;
                end
            end else if (kind < 90) begin
                mask = MASK_W'($urandom_range(0, 15));
                len = $urandom_range(1, 8);
                repeat (len) begin
                    tick_now = tick_now + TICK_W'($urandom_range(0, max_inc));
                    send_poll(mask, tick_now);
                end
                done += len;
            end else begin
                tick_now = TICK_W'($urandom);
                send_poll(MASK_W'($urandom_range(0, 15)), tick_now);
                done++;
            end
            if ($urandom_range(0, 49) == 0)
                settle();
        end
    endtask

    initial begin
        int r_rep;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed polls under the reset register values.
        send_poll(PRESS_NONE, 16'd0);
        send_poll(PRESS_UP, 16'd10);       // first press steps once
        send_poll(PRESS_UP, 16'd20);       // still inside the window, no step
        send_poll(PRESS_UP, 16'd90);       // past both delays, first repeat
        send_poll(PRESS_UP, 16'd140);      // next repeat one interval later
        send_poll(PRESS_DOWN, 16'd141);    // new button restarts the hold
        send_poll(PRESS_DOWN, 16'd142);
        send_poll(4'hF, 16'd200);          // every button at once, in order
        send_poll(PRESS_CLEAR | PRESS_DOWN, 16'd201);
        send_poll(PRESS_DOWN, 16'd202);    // still inside the window, count stays at zero
        send_poll(PRESS_IDLE, 16'd203);
        send_poll(PRESS_NONE, 16'd204);    // release
        send_poll(PRESS_UP, 16'd65530);
        send_poll(PRESS_UP, 16'd5);        // tick wraps around
        send_poll(PRESS_UP, 16'd40000);
        send_poll(PRESS_UP, 16'd14464);    // held time saturates
        send_poll(PRESS_UP, 16'd14500);
        send_poll(PRESS_CLEAR | PRESS_UP, 16'd14501);
        send_poll(PRESS_IDLE | PRESS_UP, 16'd14502);
        send_poll(PRESS_DOWN | PRESS_UP, 16'd65535);
        send_poll(PRESS_NONE, 16'd65535);
        tick_now = 16'd0;

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        random_polls(200, 60);

        // Short delays so that holds reach the tens and hundreds steps.
        program_regs(16'd4, 16'd3, 16'd3, 16'd8,
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        tx_idle_pct = 40;
        rx_idle_pct = 10;
        random_polls(220, 3);

        // Lowest values but a repeat interval of one tick: no first-press window at all.
        program_regs(16'd0, 16'd1, 16'd0, 16'd0, REG_HUNDS_AFTER + CFG_INDEX_W'(1));
        tx_idle_pct = 0;
        rx_idle_pct = 40;
        random_polls(220, 2);

        // Highest values; the delay sum is beyond the held range.
        program_regs(HOLD_SAT, HOLD_SAT, HOLD_SAT, HOLD_SAT, {CFG_INDEX_W{1'b1}});
        tx_idle_pct = 20;
        rx_idle_pct = 0;
        random_polls(200, 65535);

        program_regs(16'd40000, 16'd30000, 16'd1, 16'd2,
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        random_polls(200, 30000);

        // A zero repeat interval steps on every poll once past the delay.
        program_regs(16'd3, 16'd0, 16'd2, 16'd5,
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        random_polls(200, 2);

        r_rep = $urandom_range(1, 10);
        program_regs(CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'(r_rep),
                     CFG_DATA_W'($urandom_range(0, 10)), CFG_DATA_W'($urandom_range(0, 20)),
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        tx_idle_pct = 20;
        rx_idle_pct = 35;
        random_polls(220, 2 * r_rep);

        // One unbroken hold that repeats on every poll, long enough to pass
        // through the tens step into the hundreds step.
        program_regs(16'd0, 16'd1, 16'd10, 16'd30,
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (60) begin
            tick_now = tick_now + TICK_W'(1);
            send_poll(PRESS_UP, tick_now);
        end

        // Back to the reset values, with no idling on either side.
        program_regs(INITIAL_HOLD_RST, REPEAT_RST, TENS_AFTER_RST, HUNDS_AFTER_RST,
                     CFG_INDEX_W'($urandom_range(REG_HUNDS_AFTER + 1, 255)));
        calm = 1'b1;
        random_polls(200, 60);

        settle();
        if (sb.errors == 0)
            $display("tb_accelerating_hold_updown_counter_top: clean");
        else
            $display("tb_accelerating_hold_updown_counter_top: errors");
        $finish;
    end

endmodule

>>> files.f
src/ahc_pkg.sv
src/ahc_cfg_regs.sv
src/ahc_hold_ctrl.sv
src/ahc_digit_split.sv
src/accelerating_hold_updown_counter_top.sv
src/ahc_checker.sv
test/tb_accelerating_hold_updown_counter_top.sv
